@@ rtl/csrmv_pkg.sv @@
// ----------------------------------------------------------------------------
// csrmv_pkg: shared types and constants for the CSR sparse mat-vec core
// Field widths, request type codes, controller/datapath command and status.
// ----------------------------------------------------------------------------
package csrmv_pkg;

  localparam int unsigned TypeW = 2;
  localparam int unsigned ColW  = 10;
  localparam int unsigned RowW  = 16;
  localparam int unsigned ValW  = 32;
  localparam int unsigned SumW  = 64;

  typedef logic [TypeW-1:0] req_type_t;

  localparam req_type_t REQ_LOAD    = 2'd0;
  localparam req_type_t REQ_NONZERO = 2'd1;
  localparam req_type_t REQ_FLUSH   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic cap;       // capture request, read vector store
    logic wr;        // write vector store (load request)
    logic mul;       // register the product
    logic acc_add;   // add product into the open row
    logic acc_open;  // open a new row with the product
    logic emit;      // move the open row into the output register
    logic clear;     // close the row, zero the sum
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_type_t req_type;   // type of the request at the port
    logic      row_ok;     // port row below the row limit
    logic      row_open;
    logic      row_match;  // captured row equals the open row
    logic      out_free;   // output register can take a result now
  } stat_t;

endpackage

@@ rtl/csrmv_if.sv @@
// ----------------------------------------------------------------------------
// csrmv_if: request and result channels of the CSR sparse mat-vec core
// Valid/ready handshake, a transfer happens when both are high.
// ----------------------------------------------------------------------------
interface csrmv_req_if;
  logic                                valid;
  logic                                ready;
  logic [csrmv_pkg::TypeW-1:0]         req_type;
  logic [csrmv_pkg::ColW-1:0]          column;
  logic [csrmv_pkg::RowW-1:0]          row;
  logic signed [csrmv_pkg::ValW-1:0]   operand_value;

  modport source (output valid, req_type, column, row, operand_value, input ready);
  modport sink   (input valid, req_type, column, row, operand_value, output ready);
endinterface

interface csrmv_res_if;
  logic                                valid;
  logic                                ready;
  logic [csrmv_pkg::RowW-1:0]          out_row;
  logic signed [csrmv_pkg::SumW-1:0]   row_sum;

  modport source (output valid, out_row, row_sum, input ready);
  modport sink   (input valid, out_row, row_sum, output ready);
endinterface

@@ rtl/csr_sparse_matvec_core.sv @@
// ----------------------------------------------------------------------------
// csr_sparse_matvec_core: streaming CSR sparse matrix times dense vector
// Flow: a nonzero request passes the registered vector store read, the
//   registered 32x32 product and the accumulate step, where a closed row's
//   result enters the output register (new row nonzero), or a flush closes it.
//   Loads keep ready high; nonzero and flush hold the sequencer until done.
// Reset: rst_ni (async, low) clears the sequencer, open row and output valid;
//   the vector store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module csr_sparse_matvec_core #(
  parameter int unsigned VECTOR_DEPTH = 1024,
  parameter int unsigned ROW_LIMIT    = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  csrmv_req_if.sink       req_i,
  csrmv_res_if.source     res_o
);

  // Request flow
  //   load    : store written at the accept edge, ready stays high.
  //   nonzero : accept edge reads the store, the product is registered, then it
  //             adds into the open row, or opens a row with it (first closing a
  //             differing open row into the output register).
  //   flush   : closes the open row (if any) and zeroes the accumulator.
  // A close waits while the output register still holds an unclaimed result;
  // a result waiting there does not block new loads or same-row nonzeros.
  // Sums are Q32.32 and saturate at each add; products are exact.

  csrmv_pkg::cmd_t  cmd;
  csrmv_pkg::stat_t stat;

  csrmv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  csrmv_dpath #(
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .ROW_LIMIT    (ROW_LIMIT)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_type_i      (req_i.req_type),
    .column_i        (req_i.column),
    .row_i           (req_i.row),
    .operand_value_i (req_i.operand_value),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (res_o.valid),
    .out_ready_i     (res_o.ready),
    .out_row_o       (res_o.out_row),
    .row_sum_o       (res_o.row_sum)
  );

endmodule

@@ rtl/csrmv_dpath.sv @@
// ----------------------------------------------------------------------------
// csrmv_dpath: vector store, multiplier and saturating row accumulator
// Store read is registered, product is registered, then accumulate.
// ----------------------------------------------------------------------------
module csrmv_dpath #(
  parameter int unsigned VECTOR_DEPTH = 1024,
  parameter int unsigned ROW_LIMIT    = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [csrmv_pkg::TypeW-1:0]         req_type_i,
  input  logic [csrmv_pkg::ColW-1:0]          column_i,
  input  logic [csrmv_pkg::RowW-1:0]          row_i,
  input  logic signed [csrmv_pkg::ValW-1:0]   operand_value_i,
  input  csrmv_pkg::cmd_t                     cmd_i,
  output csrmv_pkg::stat_t                    stat_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [csrmv_pkg::RowW-1:0]          out_row_o,
  output logic signed [csrmv_pkg::SumW-1:0]   row_sum_o
);

  localparam int unsigned AddrW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int unsigned ExtW  = AddrW + csrmv_pkg::ColW;
  localparam int unsigned DepW  = 17;  // holds depth up to 65536
  localparam int unsigned LimW  = 21;  // holds limit up to 1048576
  localparam logic [DepW-1:0] DepthL = DepW'(VECTOR_DEPTH);
  localparam logic [LimW-1:0] LimitL = LimW'(ROW_LIMIT);

  logic [csrmv_pkg::ValW-1:0] store_q [VECTOR_DEPTH];
  logic [csrmv_pkg::ValW-1:0] rd_q;

  logic [ExtW-1:0]  col_ext;
  logic [AddrW-1:0] addr;
  logic             col_ok;

  logic                               col_ok_q;
  logic [csrmv_pkg::RowW-1:0]         row_q;
  logic signed [csrmv_pkg::ValW-1:0]  val_q;
  logic signed [csrmv_pkg::ValW-1:0]  vec_val;
  logic signed [csrmv_pkg::SumW-1:0]  prod_q;

  logic                               open_q;
  logic [csrmv_pkg::RowW-1:0]         cur_row_q;
  logic signed [csrmv_pkg::SumW-1:0]  sum_q;
  logic signed [csrmv_pkg::SumW-1:0]  sum_raw;
  logic signed [csrmv_pkg::SumW-1:0]  sum_sat;
  logic                               ovf;

  logic                               out_valid_q;
  logic [csrmv_pkg::RowW-1:0]         out_row_q;
  logic signed [csrmv_pkg::SumW-1:0]  out_sum_q;

  assign col_ext = ExtW'(column_i);
  assign addr    = col_ext[AddrW-1:0];
  assign col_ok  = DepW'(column_i) < DepthL;

  // vector store, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && col_ok) begin
      store_q[addr] <= operand_value_i;
    end
    if (cmd_i.cap) begin
      rd_q <= store_q[addr];
    end
  end

  // captured request and product
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      col_ok_q <= col_ok;
      row_q    <= row_i;
      val_q    <= operand_value_i;
    end
    if (cmd_i.mul) begin
      prod_q <= vec_val * val_q;
    end
  end

  // out-of-range column multiplies by zero
  assign vec_val = col_ok_q ? signed'(rd_q) : '0;

  assign sum_raw = sum_q + prod_q;
  assign ovf     = (sum_q[csrmv_pkg::SumW-1] == prod_q[csrmv_pkg::SumW-1]) &&
                   (sum_raw[csrmv_pkg::SumW-1] != sum_q[csrmv_pkg::SumW-1]);
  always_comb begin
    sum_sat = sum_raw;
    if (ovf) begin
      sum_sat = sum_q[csrmv_pkg::SumW-1] ? {1'b1, {(csrmv_pkg::SumW-1){1'b0}}}
                                         : {1'b0, {(csrmv_pkg::SumW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= 1'b0;
      cur_row_q <= '0;
      sum_q     <= '0;
    end else if (cmd_i.clear) begin
      open_q    <= 1'b0;
      cur_row_q <= '0;
      sum_q     <= '0;
    end else if (cmd_i.acc_open) begin
      open_q    <= 1'b1;
      cur_row_q <= row_q;
      sum_q     <= prod_q;
    end else if (cmd_i.acc_add) begin
      sum_q     <= sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_row_q <= cur_row_q;
      out_sum_q <= sum_q;
    end
  end

  assign stat_o.req_type  = req_type_i;
  assign stat_o.row_ok    = LimW'(row_i) < LimitL;
  assign stat_o.row_open  = open_q;
  assign stat_o.row_match = cur_row_q == row_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign row_sum_o   = out_sum_q;

endmodule

@@ rtl/csrmv_ctrl.sv @@
// ----------------------------------------------------------------------------
// csrmv_ctrl: request sequencer of the CSR sparse mat-vec core
// One request at a time: load, nonzero (read, multiply, accumulate), flush.
// ----------------------------------------------------------------------------
module csrmv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  csrmv_pkg::stat_t  stat_i,
  output csrmv_pkg::cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MUL   = 4'b0010,
    S_ACC   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.cap = 1'b1;
          unique case (stat_i.req_type)
            csrmv_pkg::REQ_LOAD: begin
              cmd_o.wr = 1'b1;
            end
            csrmv_pkg::REQ_NONZERO: begin
              if (stat_i.row_ok) begin
                state_d = S_MUL;
              end
            end
            csrmv_pkg::REQ_FLUSH: begin
              state_d = S_FLUSH;
            end
            default: ;  // reserved type, dropped
          endcase
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        if (stat_i.row_open && stat_i.row_match) begin
          cmd_o.acc_add = 1'b1;
          state_d       = S_IDLE;
        end else if (!stat_i.row_open) begin
          cmd_o.acc_open = 1'b1;
          state_d        = S_IDLE;
        end else if (stat_i.out_free) begin
          // row changed: ship the finished row, open the new one
          cmd_o.emit     = 1'b1;
          cmd_o.acc_open = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!stat_i.row_open) begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/csrmv_checker.sv @@
// ----------------------------------------------------------------------------
// csrmv_checker: port-level checks for the CSR sparse mat-vec core
// Bound to the top level; watches the request and result channels only.
// ----------------------------------------------------------------------------
module csrmv_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               req_valid_i,
  input logic                               req_ready_i,
  input logic [csrmv_pkg::TypeW-1:0]        req_type_i,
  input logic                               res_valid_i,
  input logic                               res_ready_i,
  input logic [csrmv_pkg::RowW-1:0]         res_row_i,
  input logic signed [csrmv_pkg::SumW-1:0]  res_sum_i
);

  logic req_fire;

  assign req_fire = req_valid_i && req_ready_i;

  // stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_row_i) && $stable(res_sum_i))
    else $error("result changed while stalled");

  // a load leaves ready high
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_type_i == csrmv_pkg::REQ_LOAD) |=> req_ready_i)
    else $error("ready dropped after load");

  // flush keeps the sequencer busy after acceptance
  a_flush_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_type_i == csrmv_pkg::REQ_FLUSH) |=> !req_ready_i)
    else $error("ready high right after flush");

  // loads never produce results
  a_load_no_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_type_i == csrmv_pkg::REQ_LOAD) && !res_valid_i |=> !res_valid_i)
    else $error("result appeared after load");

endmodule

bind csr_sparse_matvec_core csrmv_checker u_csrmv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_type_i  (req_i.req_type),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_row_i   (res_o.out_row),
  .res_sum_i   (res_o.row_sum)
);

@@ test/tb_csr_sparse_matvec_core.sv @@
// ----------------------------------------------------------------------------
// tb_csr_sparse_matvec_core: self-checking bench for the sparse mat-vec core
// Loads vector entries, streams row-sorted nonzeros and flushes through the
// request channel with random gaps, and checks every row sum that comes out
// against a cycle-free model of the fixed-point multiply-accumulate.
// ----------------------------------------------------------------------------
module tb_csr_sparse_matvec_core;

  // The package names only the three defined request types.
  localparam csrmv_pkg::req_type_t REQ_RESERVED = 2'd3;

  localparam int unsigned ITEMS_WANTED   = 950;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned VEC_DEPTH      = 1024;

  localparam logic [csrmv_pkg::ValW-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [csrmv_pkg::ValW-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [csrmv_pkg::ValW-1:0] Q_ONE = 32'h0001_0000;

  typedef struct packed {
    csrmv_pkg::req_type_t              kind;
    logic [csrmv_pkg::ColW-1:0]        column;
    logic [csrmv_pkg::RowW-1:0]        row;
    logic [csrmv_pkg::ValW-1:0]        value;
  } matvec_req_t;

  typedef struct packed {
    logic [csrmv_pkg::RowW-1:0]        row;
    logic [csrmv_pkg::SumW-1:0]        sum;
  } row_sum_t;

  logic clk_i;
  logic rst_ni;

  csrmv_req_if req_if ();
  csrmv_res_if res_if ();

  csr_sparse_matvec_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // --------------------------------------------------------------------------
  // Model state: mirror of the vector store plus the open row accumulator.
  // --------------------------------------------------------------------------
  logic signed [csrmv_pkg::ValW-1:0] vec_mirror [VEC_DEPTH];
  logic [csrmv_pkg::RowW-1:0]        open_row;
  longint                            open_sum;
  bit                                row_pending;

  row_sum_t    row_sums_due [$];   // finished rows still to come out
  matvec_req_t pending_reqs [$];   // stimulus not yet offered
  matvec_req_t req_on_bus;         // request currently driven

  // Stimulus side bookkeeping: which columns have been loaded so far, so that
  // nonzeros only ever read entries that hold a defined value.
  bit          gen_written [VEC_DEPTH];
  int          gen_cols [$];
  int unsigned items_queued;

  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int          src_wait;
  int          snk_wait;
  bit          src_quiet;
  bit          snk_quiet;

  // Q32.32 addition that clamps on signed overflow instead of wrapping.
  function automatic longint sat_add64(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  // Apply one accepted request to the model; a closed row lands in
  // row_sums_due. Column and row fields can never exceed the store depth or
  // the row limit at the default sizes, so no range checks are needed here.
  function automatic void mac_request(matvec_req_t rq);
    longint prod;
    case (rq.kind)
      csrmv_pkg::REQ_LOAD: begin
        vec_mirror[rq.column] = rq.value;
      end
      csrmv_pkg::REQ_NONZERO: begin
        // Q16.16 x Q16.16 is exact in Q32.32, no rounding.
        prod = longint'(vec_mirror[rq.column]) * longint'($signed(rq.value));
        if (row_pending && open_row == rq.row) begin
          open_sum = sat_add64(open_sum, prod);
        end else begin
          // any other row, higher or lower, closes the open one
          if (row_pending) row_sums_due.push_back('{row: open_row, sum: open_sum});
          open_row    = rq.row;
          open_sum    = prod;
          row_pending = 1'b1;
        end
      end
      csrmv_pkg::REQ_FLUSH: begin
        if (row_pending) row_sums_due.push_back('{row: open_row, sum: open_sum});
        row_pending = 1'b0;
        open_sum    = 0;
        open_row    = '0;
      end
      default: ;  // reserved type, no effect
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_req(csrmv_pkg::req_type_t k, int col, int row,
                                    logic [csrmv_pkg::ValW-1:0] v);
    matvec_req_t rq;
    rq.kind   = k;
    rq.column = col[csrmv_pkg::ColW-1:0];
    rq.row    = row[csrmv_pkg::RowW-1:0];
    rq.value  = v;
    pending_reqs.push_back(rq);
    if (k != REQ_RESERVED) items_queued++;
  endfunction

  function automatic void queue_load(int col, logic [csrmv_pkg::ValW-1:0] v);
    if (!gen_written[col]) begin
      gen_written[col] = 1'b1;
      gen_cols.push_back(col);
    end
    // row field is don't-care on a load, keep it toggling
    queue_req(csrmv_pkg::REQ_LOAD, col, $urandom_range(0, 65535), v);
  endfunction

  function automatic int known_col();
    return gen_cols[$urandom_range(0, gen_cols.size() - 1)];
  endfunction

  // Extremes often enough to hit saturation, unit-scale values to keep sums
  // readable, full random for bit coverage.
  function automatic logic [csrmv_pkg::ValW-1:0] rand_q16();
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2, 3:    return csrmv_pkg::ValW'($urandom_range(0, 131072)) - Q_ONE;
      default: return csrmv_pkg::ValW'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Request driver: offers pending_reqs in order, idling a random number of
  // cycles before each request, and feeds every accepted one to the model.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    int   wait_n;
    logic taken;
    if (!rst_ni) begin
      req_if.valid         <= 1'b0;
      req_if.req_type      <= csrmv_pkg::REQ_LOAD;
      req_if.column        <= '0;
      req_if.row           <= '0;
      req_if.operand_value <= '0;
      src_wait             <= 0;
    end else begin
      wait_n = src_wait;
      taken  = req_if.valid && req_if.ready;
      if (taken) begin
        mac_request(req_on_bus);
        // flip now and then into a stretch of back-to-back requests
        if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
        wait_n = src_quiet ? 0 : $urandom_range(0, 11);
      end
      if (!req_if.valid || taken) begin
        if (wait_n > 0) begin
          req_if.valid <= 1'b0;
          wait_n--;
        end else if (pending_reqs.size() > 0) begin
          req_on_bus = pending_reqs.pop_front();
          req_if.valid         <= 1'b1;
          req_if.req_type      <= req_on_bus.kind;
          req_if.column        <= req_on_bus.column;
          req_if.row           <= req_on_bus.row;
          req_if.operand_value <= req_on_bus.value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      src_wait <= wait_n;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: stalls ready at random, compares each accepted row sum
  // with the oldest one the model produced.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    int       stall_n;
    row_sum_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      snk_wait     <= 0;
    end else begin
      stall_n = snk_wait;
      if (res_if.valid && res_if.ready) begin
        if (row_sums_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, got row %0d sum %0d",
                   $time, res_if.out_row, res_if.row_sum);
        end else begin
          want = row_sums_due.pop_front();
          if (res_if.out_row !== want.row) begin
            mismatch_count++;
            $display("%0t: out_row mismatch, expected %0d, got %0d",
                     $time, want.row, res_if.out_row);
          end
          if (res_if.row_sum !== want.sum) begin
            mismatch_count++;
            $display("%0t: row_sum mismatch on row %0d, expected %0d, got %0d",
                     $time, want.row, $signed(want.sum), res_if.row_sum);
          end
        end
        if ($urandom_range(0, 39) == 0) snk_quiet = !snk_quiet;
        stall_n = snk_quiet ? 0 : $urandom_range(0, 11);
      end
      if (stall_n > 0) begin
        res_if.ready <= 1'b0;
        stall_n--;
      end else begin
        res_if.ready <= 1'b1;
      end
      snk_wait <= stall_n;
    end
  end

  // Watchdog: no handshake on either channel for too long means a hang.
  always @(posedge clk_i) begin : hang_watch
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int row_at;
    int n_rows;
    // Inputs known from time zero, reset held low at the start.
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.req_type      = csrmv_pkg::REQ_LOAD;
    req_if.column        = '0;
    req_if.row           = '0;
    req_if.operand_value = '0;
    res_if.ready         = 1'b0;
    mismatch_count       = 0;
    idle_cycles          = 0;
    items_queued         = 0;
    row_pending          = 1'b0;
    open_sum             = 0;
    open_row             = '0;

    // Directed: extreme vector entries, a zero entry, and a tiny one.
    queue_load(0, Q_MAX);
    queue_load(VEC_DEPTH - 1, Q_MIN);
    queue_load(1, Q_ONE);
    queue_load(2, 32'hFFFF_0000);
    queue_load(10'h155, '0);
    queue_load(10'h2AA, 32'h0000_0001);
    // flush with nothing open, then a reserved request; neither gives a result
    queue_req(csrmv_pkg::REQ_FLUSH, 10'h3FF, 16'hFFFF, rand_q16());
    queue_req(REQ_RESERVED, $urandom_range(0, 1023), $urandom_range(0, 65535), rand_q16());
    // row 0: small mixed-sign sum
    queue_req(csrmv_pkg::REQ_NONZERO, 1, 0, 32'h0002_0000);
    queue_req(csrmv_pkg::REQ_NONZERO, 2, 0, 32'h0000_8000);
    queue_req(csrmv_pkg::REQ_NONZERO, 10'h2AA, 0, Q_MAX);
    // top row: max * max three times clamps at the positive limit
    repeat (3) queue_req(csrmv_pkg::REQ_NONZERO, 0, 16'hFFFF, Q_MAX);
    // lower row after a higher one: min * max three times clamps negative,
    // then min * min walks back off the limit
    repeat (3) queue_req(csrmv_pkg::REQ_NONZERO, VEC_DEPTH - 1, 5, Q_MAX);
    queue_req(csrmv_pkg::REQ_NONZERO, VEC_DEPTH - 1, 5, Q_MIN);
    // reload an entry while row 5 is open; the next nonzero sees the new value
    queue_load(1, Q_MIN);
    queue_req(csrmv_pkg::REQ_NONZERO, 1, 5, Q_ONE);
    // entry holding zero contributes nothing
    queue_req(csrmv_pkg::REQ_NONZERO, 10'h155, 16'hFFFF, rand_q16());
    queue_req(csrmv_pkg::REQ_FLUSH, $urandom_range(0, 1023), $urandom_range(0, 65535),
              rand_q16());
    queue_req(csrmv_pkg::REQ_FLUSH, $urandom_range(0, 1023), $urandom_range(0, 65535),
              rand_q16());

    // Random: mostly well-formed matrices (increasing rows, each with a few
    // nonzeros on loaded columns, ended by a flush), with vector reloads in
    // between and some noise.
    while (items_queued < ITEMS_WANTED) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 8)) queue_load($urandom_range(0, 1023), rand_q16());
        end
        9: begin
          case ($urandom_range(0, 3))
            0: queue_req(REQ_RESERVED, $urandom_range(0, 1023), $urandom_range(0, 65535),
                         rand_q16());
            1: queue_req(csrmv_pkg::REQ_FLUSH, $urandom_range(0, 1023),
                         $urandom_range(0, 65535), rand_q16());
            // stray nonzero: lands in whatever row is open or opens a new one
            default: queue_req(csrmv_pkg::REQ_NONZERO, known_col(),
                               $urandom_range(0, 65535), rand_q16());
          endcase
        end
        default: begin
          row_at = ($urandom_range(0, 7) == 0) ? 65535 - $urandom_range(0, 3)
                                               : $urandom_range(0, 60000);
          n_rows = $urandom_range(1, 5);
          for (int r = 0; r < n_rows && row_at <= 65535; r++) begin
            repeat ($urandom_range(1, 6))
              queue_req(csrmv_pkg::REQ_NONZERO, known_col(), row_at, rand_q16());
            // mid-matrix reload now and then
            if ($urandom_range(0, 9) == 0) queue_load($urandom_range(0, 1023), rand_q16());
            // occasionally jump backwards, otherwise step forward
            if ($urandom_range(0, 7) == 0) row_at = $urandom_range(0, 65535);
            else row_at = row_at + $urandom_range(1, 2000);
          end
          if ($urandom_range(0, 4) != 0)
            queue_req(csrmv_pkg::REQ_FLUSH, $urandom_range(0, 1023),
                      $urandom_range(0, 65535), rand_q16());
        end
      endcase
    end
    // close whatever row is still open
    queue_req(csrmv_pkg::REQ_FLUSH, $urandom_range(0, 1023), $urandom_range(0, 65535),
              rand_q16());

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample away from the active edge to avoid racing the driver.
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_if.valid || row_sums_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
